// File: hdl/dielectric_function_eval_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DIELECTRIC_FUNCTION_EVAL_MACROS_SVH
`define DIELECTRIC_FUNCTION_EVAL_MACROS_SVH

// property that must hold at every clock edge outside reset
`define DFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define DFE_ASSERT_NXT(lbl, ante, cons, msg) \
	`DFE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hdl/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg
// Types, codes and constant tables of the dielectric function evaluator.
// ----------------------------------------------------------------------------
package dfe_pkg;

	// operation codes
	typedef enum logic {
		FUNC_VALUE = 1'b0,
		FUNC_DERIV = 1'b1
	} func_t;

	// register indexes
	localparam logic [1:0] CFG_EMAX = 2'd0;
	localparam logic [1:0] CFG_RHO0 = 2'd1;
	localparam logic [1:0] CFG_BETA = 2'd2;

	// reset values of the registers
	localparam logic [15:0] EMAX_RST = 16'd19968;
	localparam logic [31:0] RHO0_RST = 32'd6711;
	localparam logic [15:0] BETA_RST = 16'd333;

	// chain lengths
	localparam int LOG_STEPS  = 24;
	localparam int EXP_STEPS  = 24;
	localparam int DIV1_STEPS = 32;
	localparam int DIV2_STEPS = 48;

	// output clamp limits
	localparam logic signed [47:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] VAL_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		func_t       func;
		logic [31:0] density;
	} sample_t;

	typedef struct packed {
		logic signed [47:0] value;
		logic               saturated;
	} result_t;

	// per-item control carried down the whole pipe
	typedef struct packed {
		func_t       func;
		logic        zero;
		logic        tiny;
		logic [31:0] rho;
	} ctl_t;

	typedef struct packed {
		ctl_t            ctl;
		logic [1:0][4:0] ip;
	} log_side_t;

	typedef struct packed {
		ctl_t        ctl;
		logic        neg;
		logic        big;
		logic [5:0]  n;
		logic [23:0] f;
	} exp_side_t;

	typedef struct packed {
		ctl_t ctl;
		logic neg;
		logic big;
	} div_side_t;

	typedef struct packed {
		ctl_t               ctl;
		logic signed [47:0] eps;
		logic               big;
		logic [47:0]        nlow;
	} quo_side_t;

	// integer square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bw;
		x   = v;
		res = '0;
		bw  = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + bw) begin
				x   = x - (res + bw);
				res = (res >> 1) + bw;
			end else begin
				res = res >> 1;
			end
			bw = bw >> 2;
		end
		return res;
	endfunction

	// entry k is 2^(2^-(k+1)) in Q1.30, successive square roots from sqrt(2)
	function automatic logic [23:0][30:0] exp_table();
		logic [23:0][30:0] tab;
		logic [63:0]       cur;
		cur    = isqrt64(64'd1 << 61);
		tab[0] = cur[30:0];
		for (int k = 1; k < 24; k++) begin
			cur    = isqrt64(cur << 30);
			tab[k] = cur[30:0];
		end
		return tab;
	endfunction

	localparam logic [23:0][30:0] EXP_TAB = exp_table();

endpackage

// File: hdl/dfe_log_cell.sv
// ----------------------------------------------------------------------------
// dfe_log_cell
// One fraction bit of log2 for two lanes: square the mantissa, renormalize.
// ----------------------------------------------------------------------------
module dfe_log_cell #(
	parameter int SW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  logic [1:0][31:0]      m_in,
	input  logic [1:0][23:0]      frac_in,
	input  logic [SW-1:0]         side_in,
	output logic                  vld_out,
	output logic [1:0][31:0]      m_out,
	output logic [1:0][23:0]      frac_out,
	output logic [SW-1:0]         side_out
);
	logic [1:0][63:0] sq_prod;
	logic [1:0][32:0] sq;
	logic [1:0][31:0] m_nxt;
	logic [1:0][23:0] frac_nxt;
	logic             vld_s1;
	logic [1:0][31:0] m_s1;
	logic [1:0][23:0] frac_s1;
	logic [SW-1:0]    side_s1;

	// square in Q1.31, a carry into bit 32 is the next fraction bit
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sq_prod[l]  = 64'(m_in[l]) * 64'(m_in[l]);
			sq[l]       = sq_prod[l][63:31];
			m_nxt[l]    = sq[l][32] ? sq[l][32:1] : sq[l][31:0];
			frac_nxt[l] = {frac_in[l][22:0], sq[l][32]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= m_nxt;
			frac_s1 <= frac_nxt;
			side_s1 <= side_in;
		end
	end

	assign vld_out  = vld_s1;
	assign m_out    = m_s1;
	assign frac_out = frac_s1;
	assign side_out = side_s1;

endmodule

// File: hdl/dfe_exp_cell.sv
// ----------------------------------------------------------------------------
// dfe_exp_cell
// One bit of 2^f: multiply by the cell's root-of-two constant when set.
// ----------------------------------------------------------------------------
module dfe_exp_cell #(
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [30:0]   p_in,
	input  logic [30:0]   k_in,
	input  logic          bit_in,
	input  logic [SW-1:0] side_in,
	output logic          vld_out,
	output logic [30:0]   p_out,
	output logic [SW-1:0] side_out
);
	logic [61:0]   prod;
	logic          vld_s1;
	logic [30:0]   p_s1;
	logic [SW-1:0] side_s1;

	// Q1.30 product, truncated
	assign prod = 62'(p_in) * 62'(k_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= bit_in ? prod[60:30] : p_in;
			side_s1 <= side_in;
		end
	end

	assign vld_out  = vld_s1;
	assign p_out    = p_s1;
	assign side_out = side_s1;

endmodule

// File: hdl/dfe_div_cell.sv
// ----------------------------------------------------------------------------
// dfe_div_cell
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module dfe_div_cell #(
	parameter int W  = 32,
	parameter int QW = 32,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [W-1:0]  rem_in,
	input  logic [W-1:0]  dvs_in,
	input  logic [QW-1:0] quo_in,
	input  logic          bit_in,
	input  logic [SW-1:0] side_in,
	output logic          vld_out,
	output logic [W-1:0]  rem_out,
	output logic [W-1:0]  dvs_out,
	output logic [QW-1:0] quo_out,
	output logic [SW-1:0] side_out
);
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;
	logic          vld_s1;
	logic [W-1:0]  rem_s1;
	logic [W-1:0]  dvs_s1;
	logic [QW-1:0] quo_s1;
	logic [SW-1:0] side_s1;

	// remainder stays below the divisor, so the result fits in W bits
	assign trial = {rem_in, bit_in};
	assign diff  = trial - {1'b0, dvs_in};
	assign ge    = trial >= {1'b0, dvs_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? diff[W-1:0] : trial[W-1:0];
			dvs_s1  <= dvs_in;
			quo_s1  <= {quo_in[QW-2:0], ge};
			side_s1 <= side_in;
		end
	end

	assign vld_out  = vld_s1;
	assign rem_out  = rem_s1;
	assign dvs_out  = dvs_s1;
	assign quo_out  = quo_s1;
	assign side_out = side_s1;

endmodule

// File: hdl/dielectric_function_eval.sv
// ----------------------------------------------------------------------------
// dielectric_function_eval
// Density-controlled dielectric value and derivative, fixed point.
// ----------------------------------------------------------------------------
// One sample is accepted every clock while sample_stall is low.
// The pipe is a row of cells: 24 log2 squaring cells, 24 root-of-two
// multiply cells for 2^f, 32 restoring divide cells for 1/(1+r) and 48 divide
// cells for the derivative's division by density, and registered stages
// around them. The whole pipe advances together; it holds only while a
// result sits in the output register and the sink stalls. The user must
// write registers with the pipe empty; not enforced. cfg_ready is always high.
`include "dielectric_function_eval_macros.svh"

module dielectric_function_eval (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  dfe_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_stall,
	output dfe_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import dfe_pkg::*;

	// registers
	logic [15:0] emax_q;
	logic [31:0] rho0_q;
	logic [15:0] beta_q;
	logic [31:0] rho0_eff;
	logic        adv;

	// input stage
	logic             vld_s1;
	log_side_t        lside_s1;
	logic [1:0][31:0] m_s1;
	logic [1:0][4:0]  ip_c;

	// log chain
	logic             lg_vld  [LOG_STEPS+1];
	logic [1:0][31:0] lg_m    [LOG_STEPS+1];
	logic [1:0][23:0] lg_frac [LOG_STEPS+1];
	log_side_t        lg_side [LOG_STEPS+1];

	// log difference, scale, split
	logic               vld_s26;
	ctl_t               ctl_s26;
	logic signed [29:0] l_s26;
	logic               vld_s27;
	ctl_t               ctl_s27;
	logic signed [46:0] prod_s27;
	logic signed [39:0] e_c;
	logic [39:0]        a_c;
	logic               vld_s28;
	exp_side_t          eside_s28;

	// exp chain
	logic      ex_vld  [EXP_STEPS+1];
	logic [30:0] ex_p  [EXP_STEPS+1];
	exp_side_t ex_side [EXP_STEPS+1];

	// first divider
	logic        vld_s53;
	div_side_t   dside_s53;
	logic [63:0] dvs_s53;
	logic        d1_vld  [DIV1_STEPS+1];
	logic [63:0] d1_rem  [DIV1_STEPS+1];
	logic [63:0] d1_dvs  [DIV1_STEPS+1];
	logic [31:0] d1_quo  [DIV1_STEPS+1];
	div_side_t   d1_side [DIV1_STEPS+1];

	// weight, products
	logic               vld_s86;
	ctl_t               ctl_s86;
	logic [32:0]        t_s86;
	logic [31:0]        u_c;
	logic signed [16:0] em1_c;
	logic [15:0]        emag_c;
	logic               vld_s87;
	ctl_t               ctl_s87;
	logic signed [50:0] pe_s87;
	logic [63:0]        wp_s87;
	logic [32:0]        k_s87;
	logic               vld_s88;
	ctl_t               ctl_s88;
	logic signed [47:0] eps_s88;
	logic [63:0]        n_s88;
	logic [50:0]        eps_sum;
	logic               vld_s89;
	quo_side_t          qside_s89;
	logic [31:0]        rem_s89;

	// second divider
	logic        d2_vld  [DIV2_STEPS+1];
	logic [31:0] d2_rem  [DIV2_STEPS+1];
	logic [31:0] d2_dvs  [DIV2_STEPS+1];
	logic [47:0] d2_quo  [DIV2_STEPS+1];
	quo_side_t   d2_side [DIV2_STEPS+1];

	// output stage
	logic        res_vld_s138;
	result_t     res_s138;
	result_t     res_c;
	quo_side_t   fin;
	logic [47:0] q_c;

	function automatic logic [4:0] msb_pos(input logic [31:0] v);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) p = 5'(i);
		end
		return p;
	endfunction

	// register writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emax_q <= EMAX_RST;
			rho0_q <= RHO0_RST;
			beta_q <= BETA_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EMAX: emax_q <= cfg_data[15:0];
				CFG_RHO0: rho0_q <= cfg_data;
				CFG_BETA: beta_q <= cfg_data[15:0];
				default:  ;
			endcase
		end
	end

	assign rho0_eff     = (rho0_q == 32'd0) ? 32'd1 : rho0_q;
	assign adv          = !(res_vld_s138 && result_stall);
	assign sample_stall = !adv;

	// input stage: normalize both mantissas to Q1.31
	assign ip_c[0] = msb_pos(sample.density);
	assign ip_c[1] = msb_pos(rho0_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lside_s1.ctl.func  <= sample.func;
			lside_s1.ctl.zero  <= sample.density == 32'd0;
			lside_s1.ctl.tiny  <= (42'(sample.density) * 42'd1000) < 42'(rho0_eff);
			lside_s1.ctl.rho   <= sample.density;
			lside_s1.ip        <= ip_c;
			m_s1[0]            <= sample.density << (5'd31 - ip_c[0]);
			m_s1[1]            <= rho0_eff << (5'd31 - ip_c[1]);
		end
	end

	assign lg_vld[0]  = vld_s1;
	assign lg_m[0]    = m_s1;
	assign lg_frac[0] = '0;
	assign lg_side[0] = lside_s1;

	for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
		dfe_log_cell #(.SW($bits(log_side_t))) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (lg_vld[i]),
			.m_in     (lg_m[i]),
			.frac_in  (lg_frac[i]),
			.side_in  (lg_side[i]),
			.vld_out  (lg_vld[i+1]),
			.m_out    (lg_m[i+1]),
			.frac_out (lg_frac[i+1]),
			.side_out (lg_side[i+1])
		);
	end

	// e = floor(L * beta / 128), then |e| split into n and f
	assign e_c = 40'(prod_s27 >>> 7);
	assign a_c = e_c[39] ? 40'(-e_c) : e_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s26 <= 1'b0;
			vld_s27 <= 1'b0;
			vld_s28 <= 1'b0;
		end else if (adv) begin
			vld_s26 <= lg_vld[LOG_STEPS];
			vld_s27 <= vld_s26;
			vld_s28 <= vld_s27;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s26  <= lg_side[LOG_STEPS].ctl;
			l_s26    <= $signed({1'b0, lg_side[LOG_STEPS].ip[0], lg_frac[LOG_STEPS][0]})
			          - $signed({1'b0, lg_side[LOG_STEPS].ip[1], lg_frac[LOG_STEPS][1]});
			ctl_s27  <= ctl_s26;
			prod_s27 <= 47'(l_s26) * 47'($signed({1'b0, beta_q}));
			eside_s28.ctl <= ctl_s27;
			eside_s28.neg <= e_c[39];
			eside_s28.big <= a_c[39:24] >= 16'd33;
			eside_s28.n   <= (a_c[39:24] >= 16'd33) ? 6'd0 : a_c[29:24];
			eside_s28.f   <= a_c[23:0];
		end
	end

	assign ex_vld[0]  = vld_s28;
	assign ex_p[0]    = 31'h4000_0000;
	assign ex_side[0] = eside_s28;

	for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
		dfe_exp_cell #(.SW($bits(exp_side_t))) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (ex_vld[k]),
			.p_in     (ex_p[k]),
			.k_in     (EXP_TAB[k]),
			.bit_in   (ex_side[k].f[EXP_STEPS-1-k]),
			.side_in  (ex_side[k]),
			.vld_out  (ex_vld[k+1]),
			.p_out    (ex_p[k+1]),
			.side_out (ex_side[k+1])
		);
	end

	// divisor 1 + 2^a in Q34.30
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s53 <= 1'b0;
		end else if (adv) begin
			vld_s53 <= ex_vld[EXP_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dside_s53.ctl <= ex_side[EXP_STEPS].ctl;
			dside_s53.neg <= ex_side[EXP_STEPS].neg;
			dside_s53.big <= ex_side[EXP_STEPS].big;
			dvs_s53       <= (64'd1 << 30) + (64'(ex_p[EXP_STEPS]) << ex_side[EXP_STEPS].n);
		end
	end

	assign d1_vld[0]  = vld_s53;
	assign d1_rem[0]  = 64'd1 << 30;
	assign d1_dvs[0]  = dvs_s53;
	assign d1_quo[0]  = '0;
	assign d1_side[0] = dside_s53;

	for (genvar j = 0; j < DIV1_STEPS; j++) begin : g_div1
		dfe_div_cell #(.W(64), .QW(32), .SW($bits(div_side_t))) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (d1_vld[j]),
			.rem_in   (d1_rem[j]),
			.dvs_in   (d1_dvs[j]),
			.quo_in   (d1_quo[j]),
			.bit_in   (1'b0),
			.side_in  (d1_side[j]),
			.vld_out  (d1_vld[j+1]),
			.rem_out  (d1_rem[j+1]),
			.dvs_out  (d1_dvs[j+1]),
			.quo_out  (d1_quo[j+1]),
			.side_out (d1_side[j+1])
		);
	end

	// t = 1/(1+r) in Q1.32, then the products
	assign u_c    = d1_side[DIV1_STEPS].big ? 32'd0 : d1_quo[DIV1_STEPS];
	assign em1_c  = $signed({1'b0, emax_q}) - 17'sd256;
	assign emag_c = em1_c[16] ? 16'(-em1_c) : em1_c[15:0];
	assign eps_sum = 51'sd16777216 + (pe_s87 >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s86 <= 1'b0;
			vld_s87 <= 1'b0;
			vld_s88 <= 1'b0;
			vld_s89 <= 1'b0;
		end else if (adv) begin
			vld_s86 <= d1_vld[DIV1_STEPS];
			vld_s87 <= vld_s86;
			vld_s88 <= vld_s87;
			vld_s89 <= vld_s88;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s86 <= d1_side[DIV1_STEPS].ctl;
			if (d1_side[DIV1_STEPS].ctl.zero) begin
				t_s86 <= (beta_q == 16'd0) ? 33'h0_8000_0000 : 33'h1_0000_0000;
			end else if (d1_side[DIV1_STEPS].neg) begin
				t_s86 <= 33'h1_0000_0000 - 33'(u_c);
			end else begin
				t_s86 <= 33'(u_c);
			end
			ctl_s87 <= ctl_s86;
			pe_s87  <= 51'(em1_c) * 51'($signed({1'b0, t_s86}));
			wp_s87  <= 64'(t_s86) * 64'(33'h1_0000_0000 - t_s86);
			k_s87   <= {32'(beta_q) * 32'(emag_c), 1'b0};
			ctl_s88 <= ctl_s87;
			eps_s88 <= 48'(eps_sum);
			n_s88   <= 64'(wp_s87[62:32]) * 64'(k_s87);
			qside_s89.ctl  <= ctl_s88;
			qside_s89.eps  <= eps_s88;
			qside_s89.big  <= {16'd0, n_s88} >= {ctl_s88.rho, 48'd0};
			qside_s89.nlow <= n_s88[47:0];
			rem_s89        <= {16'd0, n_s88[63:48]};
		end
	end

	assign d2_vld[0]  = vld_s89;
	assign d2_rem[0]  = rem_s89;
	assign d2_dvs[0]  = qside_s89.ctl.rho;
	assign d2_quo[0]  = '0;
	assign d2_side[0] = qside_s89;

	for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
		dfe_div_cell #(.W(32), .QW(48), .SW($bits(quo_side_t))) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (d2_vld[j]),
			.rem_in   (d2_rem[j]),
			.dvs_in   (d2_dvs[j]),
			.quo_in   (d2_quo[j]),
			.bit_in   (d2_side[j].nlow[DIV2_STEPS-1-j]),
			.side_in  (d2_side[j]),
			.vld_out  (d2_vld[j+1]),
			.rem_out  (d2_rem[j+1]),
			.dvs_out  (d2_dvs[j+1]),
			.quo_out  (d2_quo[j+1]),
			.side_out (d2_side[j+1])
		);
	end

	// select, sign and clamp
	assign fin = d2_side[DIV2_STEPS];
	assign q_c = d2_quo[DIV2_STEPS];

	always_comb begin
		res_c.value     = '0;
		res_c.saturated = 1'b0;
		if (fin.ctl.func == FUNC_VALUE) begin
			res_c.value = fin.eps;
		end else if (!fin.ctl.tiny) begin
			if (!em1_c[16]) begin
				if (fin.big || q_c > 48'h8000_0000_0000) begin
					res_c.value     = VAL_MIN;
					res_c.saturated = 1'b1;
				end else begin
					res_c.value = 48'(48'd0 - q_c);
				end
			end else begin
				if (fin.big || q_c > 48'h7FFF_FFFF_FFFF) begin
					res_c.value     = VAL_MAX;
					res_c.saturated = 1'b1;
				end else begin
					res_c.value = q_c;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s138 <= 1'b0;
		end else if (adv) begin
			res_vld_s138 <= d2_vld[DIV2_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s138 <= res_c;
		end
	end

	assign result_valid = res_vld_s138;
	assign result       = res_s138;

	// checks
	`DFE_ASSERT(a_sat_at_limit, res_vld_s138 && res_s138.saturated |-> (res_s138.value == VAL_MAX || res_s138.value == VAL_MIN), "saturated result not at a limit")
	`DFE_ASSERT_NXT(a_pipe_frozen, res_vld_s138 && result_stall, $stable(d2_vld[DIV2_STEPS]) && $stable(d2_quo[DIV2_STEPS]), "pipe moved while output held")
	`DFE_ASSERT(a_exp_range, ex_vld[EXP_STEPS] |-> ex_p[EXP_STEPS][30], "2^f left [1,2)")

endmodule
